/* rtl/uld_pkg.sv */
// package for the utf-8 levenshtein distance block
// constants, command codes and the sequencer state type; no dependencies
package uld_pkg;
  localparam int MaxPoints = 128;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int RowIdxW   = $clog2(MaxPoints + 1);
  localparam int PointW    = 21;
  localparam int DistW     = 8;

  typedef enum logic [1:0] {
    CmdLoadFirst  = 2'd0,
    CmdLoadSecond = 2'd1,
    CmdCompute    = 2'd2,
    CmdNone       = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StRowStart,
    StCell,
    StCellWait,
    StFinish,
    StOut
  } state_e;
endpackage

/* rtl/uld_ram.sv */
// generic single-port-write, single-read synchronous ram with registered read
// no dependencies
module uld_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/uld_decoder.sv */
// utf-8 decoder for one string: folds bytes into code points and counts them
// depends on uld_pkg
module uld_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      clear_i,
  input  logic [7:0]                byte_i,
  output logic                      we_o,
  output logic [uld_pkg::IdxW-1:0]  waddr_o,
  output logic [uld_pkg::PointW-1:0] wdata_o,
  output logic [uld_pkg::CntW-1:0]  count_o
);
  import uld_pkg::*;

  logic [CntW-1:0]   count_q, count_d;
  logic [1:0]        rem_q, rem_d;
  logic [PointW-1:0] part_q, part_d;

  always_comb begin
    count_d = count_q;
    rem_d   = rem_q;
    part_d  = part_q;
    we_o    = 1'b0;
    waddr_o = count_q[IdxW-1:0];
    if (clear_i) begin
      count_d = '0;
      rem_d   = '0;
      part_d  = '0;
    end else if (load_i) begin
      if (rem_q != 2'd0) begin
        part_d  = {part_q[PointW-7:0], byte_i[5:0]};
        rem_d   = rem_q - 2'd1;
        we_o    = (count_q != '0);
        waddr_o = IdxW'(count_q - CntW'(1));
      end else if (count_q < CntW'(MaxPoints)) begin
        if (!byte_i[7]) begin
          part_d = PointW'(byte_i);
          rem_d  = 2'd0;
        end else if (byte_i[7:5] == 3'b110) begin
          part_d = PointW'(byte_i[4:0]);
          rem_d  = 2'd1;
        end else if (byte_i[7:4] == 4'b1110) begin
          part_d = PointW'(byte_i[3:0]);
          rem_d  = 2'd2;
        end else begin
          part_d = PointW'(byte_i[2:0]);
          rem_d  = 2'd3;
        end
        we_o    = 1'b1;
        count_d = count_q + CntW'(1);
      end
    end
  end

  assign wdata_o = part_d;
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rem_q   <= '0;
      part_q  <= '0;
    end else begin
      count_q <= count_d;
      rem_q   <= rem_d;
      part_q  <= part_d;
    end
  end
endmodule

/* rtl/utf8_levenshtein_distance.sv */
// top level of the utf-8 levenshtein distance block
// depends on uld_pkg, uld_decoder and uld_ram
//
// Load transactions (commands 0 and 1) decode the byte and write its code point
// into that string's point memory. A compute transaction holds in_stall_o while
// the single-row recurrence runs over the cost row memory: the row is first
// initialized, then each of the m rows has its setup (read of cost_row[0] and
// the first point, then the write of column 0) and then its cells in turn (the
// read of the next cell is issued while the current cell is written back, and
// the left value is carried in a register), then a final read and an output
// step. The distance waits in an output register; the next transaction is
// taken once that register is empty or drained.
module utf8_levenshtein_distance (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] distance_o
);
  import uld_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  logic   out_valid_q, out_valid_d;
  logic [DistW-1:0] dist_q, dist_d;

  // row/column counters and the running recurrence values
  logic [CntW-1:0]    i_q, i_d, j_q, j_d;
  logic [DistW-1:0]   diag_q, diag_d, left_q, left_d;
  logic [PointW-1:0]  a_pt_q, a_pt_d;

  // decoders
  logic                 ld_a, ld_b, clr;
  logic                 a_we, b_we;
  logic [IdxW-1:0]      a_wa, b_wa;
  logic [PointW-1:0]    a_wd, b_wd;
  logic [CntW-1:0]      m_cnt, n_cnt;

  // memory read ports and the cost row write port
  logic [IdxW-1:0]    a_ra, b_ra;
  logic [PointW-1:0]  a_rd, b_rd;
  logic               row_we;
  logic [RowIdxW-1:0] row_wa, row_ra;
  logic [DistW-1:0]   row_wd, row_rd;

  logic [DistW-1:0] best, up1, left1, dg;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign ld_a       = accept && (command_i == CmdLoadFirst);
  assign ld_b       = accept && (command_i == CmdLoadSecond);

  uld_decoder u_dec_a (
    .clk_i, .rst_ni, .load_i(ld_a), .clear_i(clr), .byte_i(text_byte_i),
    .we_o(a_we), .waddr_o(a_wa), .wdata_o(a_wd), .count_o(m_cnt)
  );
  uld_decoder u_dec_b (
    .clk_i, .rst_ni, .load_i(ld_b), .clear_i(clr), .byte_i(text_byte_i),
    .we_o(b_we), .waddr_o(b_wa), .wdata_o(b_wd), .count_o(n_cnt)
  );

  uld_ram #(.Width(PointW), .Depth(MaxPoints)) u_ram_a (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(a_wd), .raddr_i(a_ra), .rdata_o(a_rd)
  );
  uld_ram #(.Width(PointW), .Depth(MaxPoints)) u_ram_b (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd)
  );
  uld_ram #(.Width(DistW), .Depth(MaxPoints + 1)) u_ram_row (
    .clk_i, .we_i(row_we), .waddr_i(row_wa), .wdata_i(row_wd),
    .raddr_i(row_ra), .rdata_o(row_rd)
  );

  // saturating distance helpers
  function automatic logic [DistW-1:0] inc_sat(input logic [DistW-1:0] v);
    return (v == '1) ? v : v + DistW'(1);
  endfunction

  assign up1   = inc_sat(row_rd);
  assign left1 = inc_sat(left_q);
  // diagonal plus substitution cost
  assign dg    = (a_pt_q == b_rd) ? diag_q : inc_sat(diag_q);

  always_comb begin
    best = dg;
    if (up1 < best) begin
      best = up1;
    end
    if (left1 < best) begin
      best = left1;
    end
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    diag_d      = diag_q;
    left_d      = left_q;
    a_pt_d      = a_pt_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q && out_stall_i;
    clr         = 1'b0;
    row_we      = 1'b0;
    row_wa      = RowIdxW'(j_q);
    row_wd      = DistW'(j_q);
    row_ra      = RowIdxW'(j_q);
    a_ra        = IdxW'(i_q - CntW'(1));
    b_ra        = IdxW'(j_q - CntW'(1));
    case (state_q)
      StIdle: begin
        if (accept && command_i == CmdCompute) begin
          j_d     = '0;
          state_d = StInit;
        end
      end
      StInit: begin
        // cost_row[j] = j for j in 0..n
        row_we = 1'b1;
        row_wd = (j_q > CntW'(255)) ? DistW'(255) : DistW'(j_q);
        if (j_q == n_cnt) begin
          i_d     = CntW'(1);
          state_d = (m_cnt == '0) ? StFinish : StRowStart;
        end else begin
          j_d = j_q + CntW'(1);
        end
      end
      StRowStart: begin
        // reads cost_row[0] for diag; writes row[0]=i next cycle by value
        row_ra  = '0;
        state_d = StCell;
        j_d     = '0;
      end
      StCell: begin
        if (j_q == '0) begin
          // row_rd holds old cost_row[0]; a_rd holds first point i-1
          diag_d = row_rd;
          a_pt_d = a_rd;
          left_d = (i_q > CntW'(255)) ? DistW'(255) : DistW'(i_q);
          row_we = 1'b1;
          row_wa = '0;
          row_wd = left_d;
          if (n_cnt == '0) begin
            state_d = (i_q == m_cnt) ? StFinish : StRowStart;
            i_d     = i_q + CntW'(1);
          end else begin
            j_d     = CntW'(1);
            row_ra  = RowIdxW'(1);
            b_ra    = '0;
            state_d = StCellWait;
          end
        end else begin
          // issue reads for cell j
          row_ra  = RowIdxW'(j_q);
          state_d = StCellWait;
        end
      end
      StCellWait: begin
        // row_rd = cost_row[j] (above), b_rd = second point j-1
        row_we = 1'b1;
        row_wa = RowIdxW'(j_q);
        row_wd = best;
        left_d = best;
        diag_d = row_rd;
        if (j_q == n_cnt) begin
          i_d     = i_q + CntW'(1);
          state_d = (i_q == m_cnt) ? StFinish : StRowStart;
        end else begin
          j_d     = j_q + CntW'(1);
          row_ra  = RowIdxW'(j_q + CntW'(1));
          b_ra    = IdxW'(j_q);
          state_d = StCellWait;
        end
      end
      StFinish: begin
        row_ra  = RowIdxW'(n_cnt);
        state_d = StOut;
      end
      StOut: begin
        if (!(out_valid_q && out_stall_i)) begin
          dist_d      = row_rd;
          out_valid_d = 1'b1;
          clr         = 1'b1;
          state_d     = StIdle;
        end else begin
          row_ra = RowIdxW'(n_cnt);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q <= diag_d;
    left_q <= left_d;
    a_pt_q <= a_pt_d;
    dist_q <= dist_d;
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
endmodule
